@@ src/bresenham_line_rasterizer_core_assert.svh @@
// Assertion macros shared by the rasterizer modules.
// Needs nothing else; each user passes its own clock and active-low reset.
`ifndef BRESENHAM_LINE_RASTERIZER_CORE_ASSERT_SVH
`define BRESENHAM_LINE_RASTERIZER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BLRC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define BLRC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/blrc_pkg.sv @@
// Package for the Bresenham line rasterizer: widths, frame size, payload
// structs and the RGB565 to RGB888 colour widening. Depends on nothing.
`default_nettype none

package blrc_pkg;

    localparam int COORD_W      = 12;
    localparam int DELTA_W      = 13;
    localparam int ERR_W        = 14;
    localparam int ADDR_W       = 19;
    localparam int COLOR565_W   = 16;
    localparam int COLOR_W      = 24;
    localparam int FRAME_WIDTH  = 800;
    localparam int FRAME_HEIGHT = 600;
    localparam int IN_DATA_W    = 64;
    localparam int OUT_DATA_W   = 72;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    // One command as it enters the step engine.
    typedef struct packed {
        logic                  cmd;
        logic [COORD_W-1:0]    x_start;
        logic [COORD_W-1:0]    y_start;
        logic [COORD_W-1:0]    x_end;
        logic [COORD_W-1:0]    y_end;
        logic [COLOR565_W-1:0] color565;
    } t_cmd;

    // One pixel as it leaves the step engine, before address generation.
    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               on_line;
        logic               last;
        logic [COLOR_W-1:0] color;
    } t_pix;

    // Each field is shifted up and its top bits refill the low bits.
    function automatic logic [COLOR_W-1:0] widen565(input logic [COLOR565_W-1:0] c);
        logic [4:0] r;
        logic [5:0] g;
        logic [4:0] b;
        r = c[15:11];
        g = c[10:5];
        b = c[4:0];
        widen565 = {r, r[4:2], g, g[5:4], b, b[4:2]};
    endfunction

endpackage

`default_nettype wire

@@ src/blrc_step.sv @@
// Line state and one-pixel step of the rasterizer, with its pixel register.
// Depends on blrc_pkg and the shared assertion macro header.
`default_nettype none

`include "bresenham_line_rasterizer_core_assert.svh"

module blrc_step
    import blrc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cmd_valid,
    input  wire t_cmd i_cmd,
    output logic      o_cmd_ready,
    output logic      o_pix_valid,
    output t_pix      o_pix,
    input  wire logic i_pix_ready
);

    logic [COORD_W-1:0] r_cur_x, r_cur_y, r_end_x, r_end_y;
    logic [DELTA_W-1:0] r_delta_x, r_neg_delta_y;
    logic               r_step_x_neg, r_step_y_neg, r_active;
    logic [ERR_W-1:0]   r_error;
    logic [COLOR_W-1:0] r_color;
    logic               r_pix_valid;
    t_pix               r_pix;

    logic [COORD_W-1:0] n_cur_x, n_cur_y, n_end_x, n_end_y;
    logic [DELTA_W-1:0] n_delta_x, n_neg_delta_y;
    logic               n_step_x_neg, n_step_y_neg, n_active;
    logic [ERR_W-1:0]   n_error;
    logic [COLOR_W-1:0] n_color;
    t_pix               n_pix;

    logic               fire;
    logic signed [DELTA_W-1:0] dxs, dys;
    logic signed [ERR_W:0]     e2;
    logic               move_x, move_y;
    logic signed [ERR_W:0]     err_sum;
    logic               at_end;

    assign o_cmd_ready = !r_pix_valid || i_pix_ready;
    assign fire        = i_cmd_valid && o_cmd_ready;

    always_comb begin
        dxs = $signed({i_cmd.x_end[COORD_W-1], i_cmd.x_end})
            - $signed({i_cmd.x_start[COORD_W-1], i_cmd.x_start});
        dys = $signed({i_cmd.y_end[COORD_W-1], i_cmd.y_end})
            - $signed({i_cmd.y_start[COORD_W-1], i_cmd.y_start});
        e2      = $signed({r_error, 1'b0});
        move_x  = e2 >= $signed({{(ERR_W+1-DELTA_W){r_neg_delta_y[DELTA_W-1]}},
                                 r_neg_delta_y});
        move_y  = e2 <= $signed({{(ERR_W+1-DELTA_W){1'b0}}, r_delta_x});
        err_sum = $signed({r_error[ERR_W-1], r_error});
        if (move_x) begin
            err_sum = err_sum + $signed({{(ERR_W+1-DELTA_W){r_neg_delta_y[DELTA_W-1]}},
                                         r_neg_delta_y});
        end
        if (move_y) begin
            err_sum = err_sum + $signed({{(ERR_W+1-DELTA_W){1'b0}}, r_delta_x});
        end

        n_cur_x       = r_cur_x;
        n_cur_y       = r_cur_y;
        n_end_x       = r_end_x;
        n_end_y       = r_end_y;
        n_delta_x     = r_delta_x;
        n_neg_delta_y = r_neg_delta_y;
        n_step_x_neg  = r_step_x_neg;
        n_step_y_neg  = r_step_y_neg;
        n_error       = r_error;
        n_color       = r_color;

        case (i_cmd.cmd)
            CMD_START: begin
                n_cur_x       = i_cmd.x_start;
                n_cur_y       = i_cmd.y_start;
                n_end_x       = i_cmd.x_end;
                n_end_y       = i_cmd.y_end;
                n_delta_x     = dxs[DELTA_W-1] ? DELTA_W'(-dxs) : DELTA_W'(dxs);
                n_neg_delta_y = dys[DELTA_W-1] ? DELTA_W'(dys) : DELTA_W'(-dys);
                n_step_x_neg  = !($signed(i_cmd.x_start) < $signed(i_cmd.x_end));
                n_step_y_neg  = !($signed(i_cmd.y_start) < $signed(i_cmd.y_end));
                n_error       = ERR_W'({1'b0, n_delta_x})
                              + ERR_W'($signed(n_neg_delta_y));
                n_color       = widen565(i_cmd.color565);
            end
            CMD_STEP: begin
                if (r_active) begin
                    if (move_x) begin
                        n_cur_x = r_step_x_neg ? r_cur_x - 1'b1 : r_cur_x + 1'b1;
                    end
                    if (move_y) begin
                        n_cur_y = r_step_y_neg ? r_cur_y - 1'b1 : r_cur_y + 1'b1;
                    end
                    n_error = err_sum[ERR_W-1:0];
                end
            end
            default: begin
            end
        endcase

        at_end = (n_cur_x == n_end_x) && (n_cur_y == n_end_y);
        // A step with no line in progress reports the held pixel, writes nothing.
        if (i_cmd.cmd == CMD_STEP && !r_active) begin
            n_active      = 1'b0;
            n_pix.on_line = 1'b0;
            n_pix.last    = 1'b0;
        end else begin
            n_active      = !at_end;
            n_pix.on_line = 1'b1;
            n_pix.last    = at_end;
        end
        n_pix.x     = n_cur_x;
        n_pix.y     = n_cur_y;
        n_pix.color = n_color;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x       <= '0;
            r_cur_y       <= '0;
            r_end_x       <= '0;
            r_end_y       <= '0;
            r_delta_x     <= '0;
            r_neg_delta_y <= '0;
            r_step_x_neg  <= 1'b0;
            r_step_y_neg  <= 1'b0;
            r_error       <= '0;
            r_color       <= '0;
            r_active      <= 1'b0;
            r_pix_valid   <= 1'b0;
        end else begin
            if (fire) begin
                r_cur_x       <= n_cur_x;
                r_cur_y       <= n_cur_y;
                r_end_x       <= n_end_x;
                r_end_y       <= n_end_y;
                r_delta_x     <= n_delta_x;
                r_neg_delta_y <= n_neg_delta_y;
                r_step_x_neg  <= n_step_x_neg;
                r_step_y_neg  <= n_step_y_neg;
                r_error       <= n_error;
                r_color       <= n_color;
                r_active      <= n_active;
            end
            if (o_cmd_ready) begin
                r_pix_valid <= i_cmd_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_pix <= n_pix;
        end
    end

    assign o_pix_valid = r_pix_valid;
    assign o_pix       = r_pix;

    // The pixel register always holds the newest item, so the line state matches it.
    `BLRC_ASSERT_IMP(a_last_ends_line, i_clk, i_rst_n, r_pix_valid && r_pix.last, !r_active, "line still active after its end point")
    `BLRC_ASSERT_IMP(a_idle_step_idle, i_clk, i_rst_n, r_pix_valid && !r_pix.on_line, !r_active && !r_pix.last, "idle step reported a line pixel")
    `BLRC_ASSERT_NXT(a_idle_step_holds, i_clk, i_rst_n, fire && i_cmd.cmd == CMD_STEP && !r_active, $stable(r_cur_x) && $stable(r_cur_y) && $stable(r_error), "idle step moved the position")

endmodule

`default_nettype wire

@@ src/blrc_addr.sv @@
// Frame clipping and linear address generation, ending in the result register.
// Depends on blrc_pkg.
`default_nettype none

module blrc_addr
    import blrc_pkg::*;
#(
    parameter int FRAME_W = FRAME_WIDTH,
    parameter int FRAME_H = FRAME_HEIGHT
)
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_pix_valid,
    input  wire t_pix          i_pix,
    output logic               o_pix_ready,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output logic [COORD_W-1:0] o_pixel_x,
    output logic [COORD_W-1:0] o_pixel_y,
    output logic [ADDR_W-1:0]  o_pixel_addr,
    output logic               o_write_enable,
    output logic [COLOR_W-1:0] o_color,
    output logic               o_last
);

    localparam int                 UCOORD_W = COORD_W - 1;
    localparam int                 PROD_W   = 2 * UCOORD_W;
    localparam logic [UCOORD_W-1:0] WIDTH_C  = UCOORD_W'(FRAME_W);
    localparam logic [UCOORD_W-1:0] HEIGHT_C = UCOORD_W'(FRAME_H);

    logic               r_out_valid;
    logic [COORD_W-1:0] r_x, r_y;
    logic [ADDR_W-1:0]  r_addr;
    logic               r_we, r_last;
    logic [COLOR_W-1:0] r_color;

    logic              n_we;
    logic [PROD_W-1:0] n_lin;
    logic [ADDR_W-1:0] n_addr;
    logic              load;

    assign o_pix_ready = !r_out_valid || i_out_ready;
    assign load        = i_pix_valid && o_pix_ready;

    always_comb begin
        n_we = i_pix.on_line && !i_pix.x[COORD_W-1] && !i_pix.y[COORD_W-1]
            && (i_pix.x[UCOORD_W-1:0] < WIDTH_C) && (i_pix.y[UCOORD_W-1:0] < HEIGHT_C);
        n_lin = i_pix.y[UCOORD_W-1:0] * WIDTH_C + PROD_W'(i_pix.x[UCOORD_W-1:0]);
        n_addr = n_we ? n_lin[ADDR_W-1:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pix_ready) begin
            r_out_valid <= i_pix_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_x     <= i_pix.x;
            r_y     <= i_pix.y;
            r_addr  <= n_addr;
            r_we    <= n_we;
            r_last  <= i_pix.last;
            r_color <= i_pix.color;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_pixel_x      = r_x;
    assign o_pixel_y      = r_y;
    assign o_pixel_addr   = r_addr;
    assign o_write_enable = r_we;
    assign o_color        = r_color;
    assign o_last         = r_last;

endmodule

`default_nettype wire

@@ src/bresenham_line_rasterizer_core.sv @@
// Top level of the Bresenham line rasterizer: input register, step engine
// and address stage. Depends on blrc_pkg, blrc_step, blrc_addr and the macro header.
//
//  Channel   Direction  tdata (low bit up)                          tuser          tlast
//  s (cmd)   in         x_start, y_start, x_end, y_end, color565    cmd            -
//  m (pixel) out        pixel_x, pixel_y, pixel_addr, color_rgb888  write_enable   last
//
// Each command gives exactly one pixel transaction via input, pixel and result registers.
// One command is accepted in every cycle unless the output stalls; the rate is set by
// the step engine's error update, whose line state feeds straight back on itself.
// Reset is synchronous and active low; it clears the line state and all valid flags.
// Each of the three stages moves on when the stage after it is empty or draining,
// so a stalled result still lets earlier stages fill up before tready falls.
`default_nettype none

`include "bresenham_line_rasterizer_core_assert.svh"

module bresenham_line_rasterizer_core
    import blrc_pkg::*;
#(
    parameter int FRAME_W = FRAME_WIDTH,
    parameter int FRAME_H = FRAME_HEIGHT
)
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    input  wire logic [IN_DATA_W-1:0]  i_s_tdata,  // x_start, y_start, x_end, y_end, color565
    input  wire logic                  i_s_tuser,  // cmd
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0]      o_m_tdata,  // pixel_x, pixel_y, pixel_addr, color_rgb888, zero pad
    output logic                       o_m_tuser,  // write_enable
    output logic                       o_m_tlast   // last
);

    localparam int PAD_W        = OUT_DATA_W - 2 * COORD_W - ADDR_W - COLOR_W;
    localparam int FRAME_PIXELS = FRAME_W * FRAME_H;

    // Input register: the only place the slave-side transaction is captured.
    logic r_in_valid;
    t_cmd r_in;
    t_cmd n_in;

    logic step_ready;
    logic pix_valid, pix_ready;
    t_pix pix;

    logic [COORD_W-1:0] out_x, out_y;
    logic [ADDR_W-1:0]  out_addr;
    logic [COLOR_W-1:0] out_color;
    logic               out_we, out_last;

    assign o_s_tready = !r_in_valid || step_ready;

    always_comb begin
        n_in.cmd      = i_s_tuser;
        n_in.x_start  = i_s_tdata[11:0];
        n_in.y_start  = i_s_tdata[23:12];
        n_in.x_end    = i_s_tdata[35:24];
        n_in.y_end    = i_s_tdata[47:36];
        n_in.color565 = i_s_tdata[63:48];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in <= n_in;
        end
    end

    blrc_step u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (r_in_valid),
        .i_cmd       (r_in),
        .o_cmd_ready (step_ready),
        .o_pix_valid (pix_valid),
        .o_pix       (pix),
        .i_pix_ready (pix_ready)
    );

    blrc_addr #(
        .FRAME_W (FRAME_W),
        .FRAME_H (FRAME_H)
    ) u_addr (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_pix_valid    (pix_valid),
        .i_pix          (pix),
        .o_pix_ready    (pix_ready),
        .o_out_valid    (o_m_tvalid),
        .i_out_ready    (i_m_tready),
        .o_pixel_x      (out_x),
        .o_pixel_y      (out_y),
        .o_pixel_addr   (out_addr),
        .o_write_enable (out_we),
        .o_color        (out_color),
        .o_last         (out_last)
    );

    assign o_m_tdata = {{PAD_W{1'b0}}, out_color, out_addr, out_y, out_x};
    assign o_m_tuser = out_we;
    assign o_m_tlast = out_last;

    // A written pixel always lands inside the frame, and a skipped one carries address zero.
    `BLRC_ASSERT_IMP(a_addr_in_frame, i_clk, i_rst_n, o_m_tvalid && o_m_tuser, 32'(out_addr) < 32'(FRAME_PIXELS), "write address outside the frame")
    `BLRC_ASSERT_IMP(a_addr_zero_skip, i_clk, i_rst_n, o_m_tvalid && !o_m_tuser, out_addr == '0, "skipped pixel carries an address")
    `BLRC_ASSERT_IMP(a_empty_accepts, i_clk, i_rst_n, !r_in_valid, o_s_tready, "empty input register refuses a command")

endmodule

`default_nettype wire
